>>> rtl/awg_pkg.sv
package awg_pkg;

  localparam int CORDIC_STAGES = 24;
  localparam int DIV_BITS      = 20;

  localparam int CW   = 44;
  localparam int DFW  = 44;
  localparam int NUMW = 48;
  localparam int REMW = 58;
  localparam int OVW  = 34;

  localparam longint unsigned GAIN_TAIL =
    (2 * CORDIC_STAGES < 32) ? (64'd434688583 >> (2 * CORDIC_STAGES)) : 64'd0;
  localparam logic [29:0] INV_GAIN = 30'(64'd652032874 + GAIN_TAIL);

  localparam logic REG_CENTERLINE = 1'b0;
  localparam logic REG_OVERSHOOT  = 1'b1;

  typedef struct packed {
    logic signed [31:0] tn;
    logic signed [31:0] te;
    logic signed [31:0] cn;
    logic signed [31:0] ce;
    logic               sn;
    logic               se;
    logic               degen;
    logic [OVW-1:0]     on_n;
    logic [OVW-1:0]     on_e;
    logic [NUMW-1:0]    num_n;
    logic [NUMW-1:0]    num_e;
  } side_t;

  typedef struct packed {
    logic valid;
    logic en;
  } flow_t;

endpackage

>>> rtl/awg_front.sv
module awg_front
  import awg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  flow_t              flow_i,
  input  logic signed [31:0] tn_i,
  input  logic signed [31:0] te_i,
  input  logic signed [31:0] cn_i,
  input  logic signed [31:0] ce_i,
  input  logic [15:0]        c_i,
  input  logic [17:0]        s_i,
  output logic               valid_o,
  output logic [31:0]        a_o,
  output logic [31:0]        b_o,
  output side_t              side_o
);

  logic v1_q, v2_q, v3_q;
  logic signed [32:0] dn_q, de_q;
  logic signed [31:0] tn1_q, te1_q, cn1_q, ce1_q;

  logic [32:0] dn_abs, de_abs;
  logic [31:0] a2_q, b2_q;
  logic [49:0] ovp_n_q, ovp_e_q;
  logic [NUMW-1:0] num_n_q, num_e_q;
  logic signed [31:0] tn2_q, te2_q, cn2_q, ce2_q;
  logic sn2_q, se2_q, dg2_q;

  logic [31:0] a3_q, b3_q;
  side_t side3_q;

  assign dn_abs = dn_q[32] ? 33'(-dn_q) : 33'(dn_q);
  assign de_abs = de_q[32] ? 33'(-de_q) : 33'(de_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (flow_i.en) begin
      v1_q <= flow_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (flow_i.en) begin
      dn_q  <= {tn_i[31], tn_i} - {cn_i[31], cn_i};
      de_q  <= {te_i[31], te_i} - {ce_i[31], ce_i};
      tn1_q <= tn_i;
      te1_q <= te_i;
      cn1_q <= cn_i;
      ce1_q <= ce_i;

      a2_q    <= dn_abs[31:0];
      b2_q    <= de_abs[31:0];
      ovp_n_q <= 50'(dn_abs[31:0]) * 50'(s_i);
      ovp_e_q <= 50'(de_abs[31:0]) * 50'(s_i);
      num_n_q <= NUMW'(de_abs[31:0]) * NUMW'(c_i);
      num_e_q <= NUMW'(dn_abs[31:0]) * NUMW'(c_i);
      tn2_q   <= tn1_q;
      te2_q   <= te1_q;
      cn2_q   <= cn1_q;
      ce2_q   <= ce1_q;
      sn2_q   <= dn_q[32];
      se2_q   <= de_q[32];
      dg2_q   <= (dn_q == '0) && (de_q == '0);

      // round half up on the magnitude
      a3_q          <= a2_q;
      b3_q          <= b2_q;
      side3_q.on_n  <= OVW'((51'(ovp_n_q) + 51'd32768) >> 16);
      side3_q.on_e  <= OVW'((51'(ovp_e_q) + 51'd32768) >> 16);
      side3_q.num_n <= num_n_q;
      side3_q.num_e <= num_e_q;
      side3_q.tn    <= tn2_q;
      side3_q.te    <= te2_q;
      side3_q.cn    <= cn2_q;
      side3_q.ce    <= ce2_q;
      side3_q.sn    <= sn2_q;
      side3_q.se    <= se2_q;
      side3_q.degen <= dg2_q;
    end
  end

  assign valid_o = v3_q;
  assign a_o     = a3_q;
  assign b_o     = b3_q;
  assign side_o  = side3_q;

endmodule

>>> rtl/awg_cordic.sv
module awg_cordic
  import awg_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  flow_t          flow_i,
  input  logic [31:0]    a_i,
  input  logic [31:0]    b_i,
  input  side_t          side_i,
  output logic           valid_o,
  output logic [DFW-1:0] df_o,
  output side_t          side_o
);

  logic signed [CW-1:0] x_in [CORDIC_STAGES];
  logic signed [CW-1:0] y_in [CORDIC_STAGES];
  logic signed [CW-1:0] x_q  [CORDIC_STAGES];
  logic signed [CW-1:0] y_q  [CORDIC_STAGES];
  side_t                s_in [CORDIC_STAGES];
  side_t                s_q  [CORDIC_STAGES];
  logic                 v_in [CORDIC_STAGES];
  logic                 v_q  [CORDIC_STAGES];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    logic signed [CW-1:0] xs, ys;
    if (i == 0) begin : g_first
      assign x_in[i] = CW'({a_i, 8'b0});
      assign y_in[i] = CW'({b_i, 8'b0});
      assign s_in[i] = side_i;
      assign v_in[i] = flow_i.valid;
    end else begin : g_next
      assign x_in[i] = x_q[i-1];
      assign y_in[i] = y_q[i-1];
      assign s_in[i] = s_q[i-1];
      assign v_in[i] = v_q[i-1];
    end

    assign xs = x_in[i] >>> i;
    assign ys = y_in[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (flow_i.en) begin
        v_q[i] <= v_in[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (flow_i.en) begin
        if (!y_in[i][CW-1]) begin
          x_q[i] <= x_in[i] + ys;
          y_q[i] <= y_in[i] - xs;
        end else begin
          x_q[i] <= x_in[i] - ys;
          y_q[i] <= y_in[i] + xs;
        end
        s_q[i] <= s_in[i];
      end
    end
  end

  // gain compensation: split the radius so each product stays narrow
  logic [CW-2:0] r;
  logic [40:0]   p_hi_q;
  logic [61:0]   p_lo_q;
  side_t         sg_q, sd_q;
  logic          vg_q, vd_q;
  logic [DFW-1:0] df_sum, df_q;

  assign r      = x_q[CORDIC_STAGES-1][CW-1] ? '0 : x_q[CORDIC_STAGES-1][CW-2:0];
  assign df_sum = DFW'({p_hi_q, 2'b0}) + DFW'(p_lo_q[61:30]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vg_q <= 1'b0;
      vd_q <= 1'b0;
    end else if (flow_i.en) begin
      vg_q <= v_q[CORDIC_STAGES-1];
      vd_q <= vg_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (flow_i.en) begin
      p_hi_q <= 41'(r[CW-2:32]) * 41'(INV_GAIN);
      p_lo_q <= 62'(r[31:0]) * 62'(INV_GAIN);
      sg_q   <= s_q[CORDIC_STAGES-1];
      df_q   <= (df_sum == '0) ? DFW'(1) : df_sum;
      sd_q   <= sg_q;
    end
  end

  assign valid_o = vd_q;
  assign df_o    = df_q;
  assign side_o  = sd_q;

`ifndef NO_ASSERTIONS
  a_radius_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[CORDIC_STAGES-1] |-> !x_q[CORDIC_STAGES-1][CW-1])
    else $error("cordic radius went negative");
`endif

endmodule

>>> rtl/awg_div.sv
module awg_div
  import awg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  flow_t               flow_i,
  input  logic [DFW-1:0]      df_i,
  input  side_t               side_i,
  output logic                valid_o,
  output logic [DIV_BITS-1:0] qn_o,
  output logic [DIV_BITS-1:0] qe_o,
  output side_t               side_o
);

  localparam int TW = DFW + DIV_BITS;

  logic [REMW-1:0]     rn_q [DIV_BITS+1];
  logic [REMW-1:0]     re_q [DIV_BITS+1];
  logic [DIV_BITS-1:0] qn_q [DIV_BITS+1];
  logic [DIV_BITS-1:0] qe_q [DIV_BITS+1];
  logic [DFW-1:0]      df_q [DIV_BITS+1];
  side_t               s_q  [DIV_BITS+1];
  logic                v_q  [DIV_BITS+1];

  // numerator with half the divisor added for round half up
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (flow_i.en) begin
      v_q[0] <= flow_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (flow_i.en) begin
      rn_q[0] <= REMW'({side_i.num_n, 8'b0}) + REMW'(df_i >> 1);
      re_q[0] <= REMW'({side_i.num_e, 8'b0}) + REMW'(df_i >> 1);
      qn_q[0] <= '0;
      qe_q[0] <= '0;
      df_q[0] <= df_i;
      s_q[0]  <= side_i;
    end
  end

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_bit
    logic [TW-1:0] trial;
    logic          ge_n, ge_e;

    assign trial = TW'(df_q[k]) << (DIV_BITS - 1 - k);
    assign ge_n  = TW'(rn_q[k]) >= trial;
    assign ge_e  = TW'(re_q[k]) >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (flow_i.en) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (flow_i.en) begin
        rn_q[k+1] <= ge_n ? REMW'(TW'(rn_q[k]) - trial) : rn_q[k];
        re_q[k+1] <= ge_e ? REMW'(TW'(re_q[k]) - trial) : re_q[k];
        qn_q[k+1] <= {qn_q[k][DIV_BITS-2:0], ge_n};
        qe_q[k+1] <= {qe_q[k][DIV_BITS-2:0], ge_e};
        df_q[k+1] <= df_q[k];
        s_q[k+1]  <= s_q[k];
      end
    end
  end

  assign valid_o = v_q[DIV_BITS];
  assign qn_o    = qn_q[DIV_BITS];
  assign qe_o    = qe_q[DIV_BITS];
  assign side_o  = s_q[DIV_BITS];

`ifndef NO_ASSERTIONS
  a_rem_n: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[DIV_BITS] |-> (rn_q[DIV_BITS] < REMW'(df_q[DIV_BITS])))
    else $error("north quotient overflowed");
  a_rem_e: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[DIV_BITS] |-> (re_q[DIV_BITS] < REMW'(df_q[DIV_BITS])))
    else $error("east quotient overflowed");
`endif

endmodule

>>> rtl/approach_waypoint_geometry.sv
// Channel  | valid    | stall    | payload
// input    | valid_i  | stall_o  | target_north_i .. current_east_i
// output   | valid_o  | stall_i  | overshoot_*_o, left_point_*_o, right_point_*_o, degenerate_o
// config   | cfg_we_i | -        | cfg_idx_i, cfg_data_i
// One item enters per cycle unless the output stalls; the pipeline runs through the front
// stages, the CORDIC iteration stages, the bit-per-stage divider and an output register.
// Reset clears all valid bits and loads 20 m centerline and 1.2 overshoot scale.
// A stalled result holds the whole pipeline; no transfer is lost or repeated.
module approach_waypoint_geometry
  import awg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic signed [31:0] target_north_i,
  input  logic signed [31:0] target_east_i,
  input  logic signed [31:0] current_north_i,
  input  logic signed [31:0] current_east_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [31:0] overshoot_north_o,
  output logic signed [31:0] overshoot_east_o,
  output logic signed [31:0] left_point_north_o,
  output logic signed [31:0] left_point_east_o,
  output logic signed [31:0] right_point_north_o,
  output logic signed [31:0] right_point_east_o,
  output logic               degenerate_o,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [17:0]        cfg_data_i
);

  logic [15:0] c_q;
  logic [17:0] s_q;
  logic        vo_q;
  flow_t       flow;
  flow_t       c_flow;
  flow_t       d_flow;

  logic           f_valid, c_valid, d_valid;
  logic [31:0]    f_a, f_b;
  side_t          f_side, c_side, d_side;
  logic [DFW-1:0] df;
  logic [DIV_BITS-1:0] qn, qe;

  logic signed [31:0] ovn_q, ove_q, ln_q, le_q, rn_q, re_q;
  logic               dg_q;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -36'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  assign stall_o    = vo_q && stall_i;
  assign flow.en    = !stall_o;
  assign flow.valid = valid_i;

  assign c_flow.en    = !stall_o;
  assign c_flow.valid = f_valid;
  assign d_flow.en    = !stall_o;
  assign d_flow.valid = c_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q <= 16'd5120;
      s_q <= 18'd78643;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CENTERLINE: c_q <= cfg_data_i[15:0];
        REG_OVERSHOOT:  s_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  awg_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flow_i  (flow),
    .tn_i    (target_north_i),
    .te_i    (target_east_i),
    .cn_i    (current_north_i),
    .ce_i    (current_east_i),
    .c_i     (c_q),
    .s_i     (s_q),
    .valid_o (f_valid),
    .a_o     (f_a),
    .b_o     (f_b),
    .side_o  (f_side)
  );

  awg_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flow_i  (c_flow),
    .a_i     (f_a),
    .b_i     (f_b),
    .side_i  (f_side),
    .valid_o (c_valid),
    .df_o    (df),
    .side_o  (c_side)
  );

  awg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flow_i  (d_flow),
    .df_i    (df),
    .side_i  (c_side),
    .valid_o (d_valid),
    .qn_o    (qn),
    .qe_o    (qe),
    .side_o  (d_side)
  );

  logic signed [35:0] tn36, te36, cn36, ce36, on36, oe36, qn36, qe36;
  assign tn36 = 36'(d_side.tn);
  assign te36 = 36'(d_side.te);
  assign cn36 = 36'(d_side.cn);
  assign ce36 = 36'(d_side.ce);
  assign on36 = 36'(d_side.on_n);
  assign oe36 = 36'(d_side.on_e);
  assign qn36 = 36'(qn);
  assign qe36 = 36'(qe);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (flow.en) begin
      vo_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (flow.en) begin
      dg_q <= d_side.degen;
      if (d_side.degen) begin
        ovn_q <= '0;
        ove_q <= '0;
        ln_q  <= '0;
        le_q  <= '0;
        rn_q  <= '0;
        re_q  <= '0;
      end else begin
        ovn_q <= sat32(d_side.sn ? cn36 - on36 : cn36 + on36);
        ove_q <= sat32(d_side.se ? ce36 - oe36 : ce36 + oe36);
        ln_q  <= sat32(d_side.se ? tn36 - qn36 : tn36 + qn36);
        rn_q  <= sat32(d_side.se ? tn36 + qn36 : tn36 - qn36);
        le_q  <= sat32(d_side.sn ? te36 + qe36 : te36 - qe36);
        re_q  <= sat32(d_side.sn ? te36 - qe36 : te36 + qe36);
      end
    end
  end

  assign valid_o             = vo_q;
  assign overshoot_north_o   = ovn_q;
  assign overshoot_east_o    = ove_q;
  assign left_point_north_o  = ln_q;
  assign left_point_east_o   = le_q;
  assign right_point_north_o = rn_q;
  assign right_point_east_o  = re_q;
  assign degenerate_o        = dg_q;

`ifndef NO_ASSERTIONS
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && degenerate_o) |-> (overshoot_north_o == '0 && left_point_east_o == '0 &&
                                   right_point_north_o == '0 && right_point_east_o == '0))
    else $error("degenerate result carries nonzero points");
`endif

endmodule

>>> dv/tb_approach_waypoint_geometry.sv
module tb_approach_waypoint_geometry;
  import awg_pkg::*;

  typedef struct {
    logic signed [31:0] tn;
    logic signed [31:0] te;
    logic signed [31:0] cn;
    logic signed [31:0] ce;
  } fix_t;

  typedef struct {
    logic signed [31:0] ovn;
    logic signed [31:0] ove;
    logic signed [31:0] lpn;
    logic signed [31:0] lpe;
    logic signed [31:0] rpn;
    logic signed [31:0] rpe;
    logic               degen;
  } waypoints_t;

  logic               clk_i;
  logic               rst_ni;
  logic               valid_i;
  logic               stall_o;
  logic signed [31:0] target_north_i;
  logic signed [31:0] target_east_i;
  logic signed [31:0] current_north_i;
  logic signed [31:0] current_east_i;
  logic               valid_o;
  logic               stall_i;
  logic signed [31:0] overshoot_north_o;
  logic signed [31:0] overshoot_east_o;
  logic signed [31:0] left_point_north_o;
  logic signed [31:0] left_point_east_o;
  logic signed [31:0] right_point_north_o;
  logic signed [31:0] right_point_east_o;
  logic               degenerate_o;
  logic               cfg_we_i;
  logic               cfg_idx_i;
  logic [17:0]        cfg_data_i;

  approach_waypoint_geometry dut (.*);

  fix_t       fix_queue[$];
  waypoints_t waypoint_queue[$];
  int         error_count;
  int         send_idle;
  int         recv_idle;
  logic       hold_req;
  int         hold_left;
  logic [15:0] centerline;
  logic [17:0] overshoot;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // c*|v|*2^8/df rounded half up on the magnitude, then signed
  function automatic longint lateral_term(input longint unsigned c, input longint v,
                                          input longint unsigned df);
    longint unsigned num;
    longint unsigned q;
    num = (c * longint'(v < 0 ? -v : v)) << 8;
    q = (num + (df >> 1)) / df;
    return v < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic waypoints_t predict_waypoints(input fix_t p, input logic [15:0] c,
                                                    input logic [17:0] s);
    waypoints_t w;
    longint dn, de, x, y, xs, ys, odn, ode, lat_n, lat_e;
    longint unsigned an, ae, r, g, df;
    dn = longint'(p.tn) - longint'(p.cn);
    de = longint'(p.te) - longint'(p.ce);
    w = '{default: '0};
    if (dn == 0 && de == 0) begin
      w.degen = 1'b1;
      return w;
    end
    an = dn < 0 ? -dn : dn;
    ae = de < 0 ? -de : de;
    odn = longint'((an * s + 32768) >> 16);
    ode = longint'((ae * s + 32768) >> 16);
    if (dn < 0) odn = -odn;
    if (de < 0) ode = -ode;
    x = longint'(an << 8);
    y = longint'(ae << 8);
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
      end else begin
        x = x - ys;
        y = y + xs;
      end
    end
    r = x < 0 ? 0 : x;
    g = INV_GAIN;
    // split the product so it stays inside 64 bits
    df = (((r >> 32) * g) << 2) + (((r & 64'hffffffff) * g) >> 30);
    if (df == 0) df = 1;
    lat_n = lateral_term(c, de, df);
    lat_e = lateral_term(c, dn, df);
    w.ovn = clamp32(longint'(p.cn) + odn);
    w.ove = clamp32(longint'(p.ce) + ode);
    w.lpn = clamp32(longint'(p.cn) + dn + lat_n);
    w.lpe = clamp32(longint'(p.ce) + de - lat_e);
    w.rpn = clamp32(longint'(p.cn) + dn - lat_n);
    w.rpe = clamp32(longint'(p.ce) + de + lat_e);
    return w;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (got !== want) begin
      $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
      error_count++;
    end
  endtask

  // driver: hold the payload while stalled, advance on transfer
  always @(posedge clk_i or negedge rst_ni) begin
    fix_t nx;
    if (!rst_ni) begin
      valid_i         <= 1'b0;
      target_north_i  <= '0;
      target_east_i   <= '0;
      current_north_i <= '0;
      current_east_i  <= '0;
    end else begin
      if (valid_i && !stall_o)
        waypoint_queue.insert(waypoint_queue.size(), predict_waypoints('{target_north_i,
            target_east_i, current_north_i, current_east_i}, centerline, overshoot));
      if (!valid_i || !stall_o) begin
        if (fix_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
          nx = fix_queue.pop_front();
          target_north_i  <= nx.tn;
          target_east_i   <= nx.te;
          current_north_i <= nx.cn;
          current_east_i  <= nx.ce;
          valid_i         <= 1'b1;
        end else begin
          valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_i   <= 1'b0;
      hold_left <= 0;
    end else if (hold_req) begin
      hold_left <= 300;
      stall_i   <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      stall_i   <= 1'b1;
    end else begin
      stall_i <= $urandom_range(99) < recv_idle;
    end
  end

  always @(posedge clk_i) begin
    waypoints_t w;
    if (rst_ni && valid_o && !stall_i) begin
      if (waypoint_queue.size() == 0) begin
        $display("unexpected result transfer at %0t", $realtime);
        error_count++;
      end else begin
        w = waypoint_queue.pop_front();
        report_mismatch("overshoot_north", overshoot_north_o, w.ovn);
        report_mismatch("overshoot_east", overshoot_east_o, w.ove);
        report_mismatch("left_point_north", left_point_north_o, w.lpn);
        report_mismatch("left_point_east", left_point_east_o, w.lpe);
        report_mismatch("right_point_north", right_point_north_o, w.rpn);
        report_mismatch("right_point_east", right_point_east_o, w.rpe);
        report_mismatch("degenerate", 32'(degenerate_o), 32'(w.degen));
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [17:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_CENTERLINE) centerline = data[15:0];
    else overshoot = data;
  endtask

  task automatic wait_drained();
    while (fix_queue.size() != 0 || valid_i || waypoint_queue.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic push_fix(input logic [31:0] tn, te, cn, ce);
    fix_queue.insert(fix_queue.size(), '{tn, te, cn, ce});
  endtask

  // mostly short approaches, some wild and degenerate ones
  task automatic push_random();
    logic [31:0] cn, ce;
    int sel;
    cn = $urandom();
    ce = $urandom();
    sel = $urandom_range(9);
    if (sel < 3) push_fix($urandom(), $urandom(), cn, ce);
    else if (sel == 3) push_fix(cn, ce, cn, ce);
    else if (sel == 4) push_fix(cn + $urandom_range(4), ce - $urandom_range(4), cn, ce);
    else begin
      cn = $signed(cn) >>> $urandom_range(8, 20);
      ce = $signed(ce) >>> $urandom_range(8, 20);
      push_fix(cn + ($signed($urandom()) >>> $urandom_range(8, 24)),
               ce + ($signed($urandom()) >>> $urandom_range(8, 24)), cn, ce);
    end
  endtask

  initial begin
    logic [17:0] c_set[5];
    logic [17:0] s_set[5];
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_CENTERLINE;
    cfg_data_i  = '0;
    hold_req    = 1'b0;
    error_count = 0;
    send_idle   = 13;
    recv_idle   = 68;
    centerline  = 16'd5120;
    overshoot   = 18'd78643;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values first
    push_fix(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000);
    push_fix(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
    push_fix(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
    push_fix(32'h12345678, 32'h0badcafe, 32'h12345678, 32'h0badcafe);
    push_fix(0, 0, 0, 0);
    push_fix(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    push_fix(1, 0, 0, 0);
    push_fix(0, 1, 0, 0);
    push_fix(-1, 0, 0, 0);
    push_fix(0, -1, 0, 0);
    push_fix(32'd2560, 32'd0, 0, 0);
    push_fix(32'd0, -32'sd2560, 32'd1000, 32'd1000);
    push_fix(32'd768, 32'd1024, 0, 0);
    push_fix(32'h7fffff00, 32'h7fffff00, 32'h7ffff000, 32'h7ffff000);
    push_fix(32'hffffffff, 32'hffffffff, 32'h00000001, 32'h00000001);
    push_fix(32'h00010000, -32'sh00010000, -32'sh00010000, 32'h00010000);
    wait_drained();

    c_set = '{18'd5120, 18'd0, 18'd65535, 18'd0, 18'd777};
    s_set = '{18'd78643, 18'd262143, 18'd0, 18'd0, 18'd65536};
    for (int mode = 0; mode < 3; mode++) begin
      send_idle = mode == 0 ? 13 : (mode == 1 ? 68 : 0);
      recv_idle = mode == 0 ? 68 : (mode == 1 ? 13 : 0);
      for (int k = 0; k < 5; k++) begin
        write_reg(REG_CENTERLINE, k == 4 ? 18'($urandom()) : c_set[k]);
        write_reg(REG_OVERSHOOT, k == 4 ? 18'($urandom()) : s_set[k]);
        repeat (110) push_random();
        if (mode == 2 && k == 0) begin
          // long receiver hold while the sender keeps offering
          @(posedge clk_i);
          hold_req <= 1'b1;
          @(posedge clk_i);
          hold_req <= 1'b0;
        end
        wait_drained();
      end
    end

    repeat (70) @(posedge clk_i);
    if (error_count == 0 && waypoint_queue.size() == 0) begin
      $display("PASS approach_waypoint_geometry");
    end else begin
      $display("FAIL approach_waypoint_geometry");
    end
    $finish;
  end

  initial begin
    #(20 * 600000);
    $display("FAIL approach_waypoint_geometry");
    $finish;
  end

endmodule

>>> sim.f
rtl/awg_pkg.sv
rtl/awg_front.sv
rtl/awg_cordic.sv
rtl/awg_div.sv
rtl/approach_waypoint_geometry.sv
dv/tb_approach_waypoint_geometry.sv
